// ===== rtl/core/wpsc_pkg.sv =====
// Shared types and constants of the window pair-sum checker.
// Used by wpsc_cell, window_pair_sum_checker and the testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package wpsc_pkg;

    localparam int VALUE_W        = 64;
    localparam int CFG_W          = 5;
    localparam int MIN_WINDOW     = 2;
    localparam int MAX_WINDOW_DEF = 25;
    localparam int WINDOW_RESET   = 25;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Per-cycle commands broadcast to every cell of the chain
    typedef struct packed {
        logic insert;   // shift the stored values one cell up
        logic load;     // start a scan: take neighbor value, clear hit
        logic scan;     // compare, then shift the rotating copy down
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== rtl/core/window_pair_sum_checker.sv =====
// A prelude item gives its result the cycle after its transfer; a checked item gives
//   its result after a scan in which the rotating copy passes every neighbor.
// Prelude items are taken one per cycle while the result register is free and no
//   size write waits; a checked item holds off both until its result is posted.
// Reset: synchronous, active low; window size goes to 25, prelude restarts, failure
//   flag clears. Stored values are not cleared; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module window_pair_sum_checker
    import wpsc_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration write channel
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [CFG_W-1:0]   i_window_size,
    // input item channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [VALUE_W-1:0] i_value,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_checked,
    output logic                    o_pair_found,
    output logic                    o_first_failure
);

    // Width that holds any window size up to MAX_WINDOW
    localparam int WW = $clog2(MAX_WINDOW + 1);
    // Common width for clamping the written size
    localparam int CW = (WW > CFG_W) ? WW : CFG_W;
    // Reset window size, saturated to the number of cells
    localparam int RESET_SIZE = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

    t_state             r_state;
    t_state             n_state;
    logic [WW-1:0]      r_window;
    logic [WW-1:0]      r_fill;
    logic [WW-1:0]      r_step;
    logic [VALUE_W-1:0] r_target;
    logic               r_failure_seen;
    logic               r_out_valid;
    logic               r_out_checked;
    logic               r_out_found;
    logic               r_out_first;

    logic               cfg_fire;
    logic               in_fire;
    logic               out_free;
    logic               prelude;
    logic               finish;
    logic               found;
    logic               first_fail;
    logic [WW-1:0]      clamped_size;
    logic [CW-1:0]      cfg_ext;
    logic [VALUE_W-1:0] shift_in;
    t_cell_ctrl         cell_ctrl;

    logic [VALUE_W-1:0] cell_value [MAX_WINDOW];
    logic [VALUE_W-1:0] cell_rot   [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] cell_rot_vld;
    logic [MAX_WINDOW-1:0] cell_hit;
    logic [MAX_WINDOW-1:0] load_vld;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    // The result register is free when empty or being drained this cycle.
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_cfg_ready = (r_state == ST_IDLE);
    // Configuration takes priority over a new item in the same cycle.
    assign o_in_ready  = (r_state == ST_IDLE) && out_free && !i_cfg_valid;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign in_fire     = i_in_valid && o_in_ready;

    // Item belongs to the prelude while the window is still filling.
    assign prelude     = (r_fill < r_window);

    // Saturate the written window size to the supported range.
    assign cfg_ext = CW'(i_window_size);
    always_comb begin
        priority if (cfg_ext < CW'(MIN_WINDOW)) begin
            clamped_size = WW'(MIN_WINDOW);
        end else if (cfg_ext > CW'(MAX_WINDOW)) begin
            clamped_size = WW'(MAX_WINDOW);
        end else begin
            clamped_size = WW'(cfg_ext);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && !prelude) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_step == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs to the chain and the result path
    // ------------------------------------------------------------------
    always_comb begin
        cell_ctrl = '0;
        finish    = 1'b0;
        shift_in  = i_value;
        unique case (r_state)
            ST_IDLE: begin
                // prelude item: store at once; checked item: start the scan
                cell_ctrl.insert = in_fire && prelude;
                cell_ctrl.load   = in_fire && !prelude;
                finish           = in_fire && prelude;
            end
            ST_SCAN: begin
                cell_ctrl.scan = 1'b1;
            end
            ST_DONE: begin
                // retire the oldest value only once the result can be posted
                cell_ctrl.insert = out_free;
                finish           = out_free;
                shift_in         = r_target;
            end
            default: begin
                cell_ctrl = '0;
            end
        endcase
    end

    // A pair was found if any cell saw a matching sum during the scan.
    assign found      = (r_state == ST_DONE) && (|cell_hit);
    assign first_fail = (r_state == ST_DONE) && !found && !r_failure_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_window       <= WW'(RESET_SIZE);
            r_fill         <= '0;
            r_step         <= '0;
            r_failure_seen <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            // A write restarts the prelude; the failure flag is kept.
            if (cfg_fire) begin
                r_window <= clamped_size;
                r_fill   <= '0;
            end else if (in_fire && prelude) begin
                r_fill <= r_fill + WW'(1);
            end

            // Scan step counter: the copy starts one cell ahead, so it runs W-2 downto 0.
            if (cell_ctrl.load) begin
                r_step <= r_window - WW'(2);
            end else if (r_state == ST_SCAN) begin
                r_step <= r_step - WW'(1);
            end

            if (finish && first_fail) begin
                r_failure_seen <= 1'b1;
            end

            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: target of the scan and the posted result
    always_ff @(posedge i_clk) begin
        if (cell_ctrl.load) begin
            r_target <= i_value;
        end
        if (finish) begin
            r_out_checked <= (r_state == ST_DONE);
            r_out_found   <= found;
            r_out_first   <= first_fail;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_checked       = r_out_checked;
    assign o_pair_found    = r_out_found;
    assign o_first_failure = r_out_first;

    // ------------------------------------------------------------------
    // Chain of cells: cell 0 holds the newest value. The rotating copy
    // starts at the upper neighbor and walks down one cell per step, so
    // cell i meets every cell j > i inside the window exactly once.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        localparam logic [WW:0] NEXT_POS = (WW + 1)'(g + 1);

        logic [VALUE_W-1:0] prev_value;
        logic [VALUE_W-1:0] next_value;
        logic [VALUE_W-1:0] next_rot;
        logic               next_rot_vld;

        assign load_vld[g] = (NEXT_POS < {1'b0, r_window});

        if (g == 0) begin : g_head
            assign prev_value = shift_in;
        end else begin : g_body
            assign prev_value = cell_value[g-1];
        end

        // Rotating copy seen by cell g: the copy held by its upper neighbor.
        if (g == MAX_WINDOW - 1) begin : g_tail
            assign next_value   = '0;
            assign next_rot     = '0;
            assign next_rot_vld = 1'b0;
        end else begin : g_inner
            assign next_value   = cell_value[g+1];
            assign next_rot     = cell_rot[g+1];
            assign next_rot_vld = cell_rot_vld[g+1];
        end

        wpsc_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctrl         (cell_ctrl),
            .i_target       (r_target),
            .i_prev_value   (prev_value),
            .i_next_value   (next_value),
            .i_load_vld     (load_vld[g]),
            .i_next_rot     (next_rot),
            .i_next_rot_vld (next_rot_vld),
            .o_value        (cell_value[g]),
            .o_rot          (cell_rot[g]),
            .o_rot_vld      (cell_rot_vld[g]),
            .o_hit          (cell_hit[g])
        );
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_step_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ((WW + 1)'(r_step) + (WW + 1)'(2) <= (WW + 1)'(r_window)))
        else $error("scan step counter beyond window");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_window)
        else $error("prelude count exceeds window size");

    a_failure_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failure_seen |=> r_failure_seen)
        else $error("failure flag cleared without reset");

    a_first_is_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_first_failure) |-> (o_checked && !o_pair_found))
        else $error("first failure flagged on a passing or unchecked item");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (!o_in_ready && !o_cfg_ready))
        else $error("channel ready during scan");

endmodule

`default_nettype wire

// ===== rtl/core/wpsc_cell.sv =====
// One cell of the window chain: a stored value, a rotating copy and a hit flag.
// Depends on wpsc_pkg for the value width and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module wpsc_cell
    import wpsc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cell_ctrl         i_ctrl,
    input  wire logic [VALUE_W-1:0] i_target,
    input  wire logic [VALUE_W-1:0] i_prev_value,
    input  wire logic [VALUE_W-1:0] i_next_value,
    input  wire logic               i_load_vld,
    input  wire logic [VALUE_W-1:0] i_next_rot,
    input  wire logic               i_next_rot_vld,
    output logic [VALUE_W-1:0]      o_value,
    output logic [VALUE_W-1:0]      o_rot,
    output logic                    o_rot_vld,
    output logic                    o_hit
);

    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] r_rot;
    logic               r_rot_vld;
    logic               r_hit;
    logic [VALUE_W-1:0] pair_sum;
    logic               match;

    // Sum wraps modulo 2^64 by width
    assign pair_sum = r_value + r_rot;
    assign match    = r_rot_vld && (pair_sum == i_target);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert) begin
            r_value <= i_prev_value;
        end
        if (i_ctrl.load) begin
            r_rot <= i_next_value;
        end else if (i_ctrl.scan) begin
            r_rot <= i_next_rot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_vld <= 1'b0;
            r_hit     <= 1'b0;
        end else if (i_ctrl.load) begin
            r_rot_vld <= i_load_vld;
            r_hit     <= 1'b0;
        end else if (i_ctrl.scan) begin
            r_rot_vld <= i_next_rot_vld;
            if (match) begin
                r_hit <= 1'b1;
            end
        end
    end

    assign o_value   = r_value;
    assign o_rot     = r_rot;
    assign o_rot_vld = r_rot_vld;
    assign o_hit     = r_hit;

endmodule

`default_nettype wire

// ===== dv/tb_window_pair_sum_checker.sv =====
// Self-checking testbench for window_pair_sum_checker: a directed opening, then random
// streams over many window sizes, with a local predictor. Depends on wpsc_pkg and the DUT.
`timescale 1ns / 1ps

module tb_window_pair_sum_checker;
    import wpsc_pkg::*;

    // Two copies of the ring state: one steers stimulus generation, one
    // predicts the results of transfers as the DUT accepts them.
    localparam int STIM_VIEW   = 0;
    localparam int DUT_VIEW    = 1;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int DIRECTED_N  = 16;

    typedef struct packed {
        logic checked;
        logic pair_found;
        logic first_failure;
    } t_verdict;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               drain_first;  // hold until every result is back
    } t_pending;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_cfg_valid     = 1'b0;
    logic [CFG_W-1:0]   i_window_size   = '0;
    logic               i_in_valid      = 1'b0;
    logic [VALUE_W-1:0] i_value         = '0;
    logic               i_out_ready     = 1'b0;
    logic               o_cfg_ready;
    logic               o_in_ready;
    logic               o_out_valid;
    logic               o_checked;
    logic               o_pair_found;
    logic               o_first_failure;

    // Ring state of the predictor, indexed by view
    logic [VALUE_W-1:0] ring_val [2][MAX_WINDOW_DEF];
    int unsigned        ring_fill [2];
    int unsigned        ring_wr   [2];
    int unsigned        ring_size [2];
    bit                 ring_failed [2];

    t_pending    feed_q [$];
    t_verdict    verdict_q [$];
    bit          steady_run   = 1'b0;
    int unsigned error_count  = 0;
    int unsigned results_seen = 0;
    int unsigned checked_seen = 0;
    int unsigned pairs_seen   = 0;
    int unsigned firsts_seen  = 0;
    int unsigned settings_run = 0;
    int unsigned cycle_count  = 0;

    // Opening stream for a window of two: wraparound sums, first and repeated
    // failures, a value that is only the double of one stored entry, and
    // equal values at distinct positions.
    logic [VALUE_W-1:0] opening_vals [DIRECTED_N] = '{
        64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFFE, 64'h0, 64'h1, 64'h5, 64'h7, 64'hA, 64'h11,
        64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h0,
        64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'hFFFF_FFFF_FFFF_FFFF
    };

    window_pair_sum_checker DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_window_size   (i_window_size),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_checked       (o_checked),
        .o_pair_found    (o_pair_found),
        .o_first_failure (o_first_failure)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Saturate a written size into the legal window range.
    function automatic int unsigned window_clamp(input logic [CFG_W-1:0] raw);
        if (raw < MIN_WINDOW) return MIN_WINDOW;
        if (raw > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
        return raw;
    endfunction

    // A size write restarts the prelude; the failure flag survives it.
    function automatic void window_restart(input int who, input logic [CFG_W-1:0] raw);
        ring_size[who] = window_clamp(raw);
        ring_fill[who] = 0;
        ring_wr[who]   = 0;
    endfunction

    // Advance one view by one item and return the result it should give.
    function automatic t_verdict window_predict(input int who, input logic [VALUE_W-1:0] v);
        t_verdict           r;
        logic [VALUE_W-1:0] total;
        r = '0;
        if (ring_fill[who] < ring_size[who]) begin
            ring_fill[who]++;
        end else begin
            r.checked = 1'b1;
            for (int a = 0; a < ring_size[who]; a++) begin
                for (int b = a + 1; b < ring_size[who]; b++) begin
                    total = ring_val[who][a] + ring_val[who][b];
                    if (total == v) r.pair_found = 1'b1;
                end
            end
            if (!r.pair_found && !ring_failed[who]) begin
                r.first_failure  = 1'b1;
                ring_failed[who] = 1'b1;
            end
        end
        if (ring_wr[who] >= ring_size[who]) ring_wr[who] = 0;
        ring_val[who][ring_wr[who]] = v;
        ring_wr[who]++;
        if (ring_wr[who] >= ring_size[who]) ring_wr[who] = 0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Pick the next value from the stimulus view: prelude items mix wide,
    // tiny and near-max values; checked items are mostly true pair sums,
    // with near misses, doubled single entries and raw noise mixed in.
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned        w;
        int unsigned        roll;
        int unsigned        a;
        int unsigned        b;
        logic [VALUE_W-1:0] total;
        w    = ring_size[STIM_VIEW];
        roll = $urandom_range(0, 99);
        if (ring_fill[STIM_VIEW] < w) begin
            if (roll < 50) return {$urandom, $urandom};
            if (roll < 80) return VALUE_W'($urandom_range(0, 15));
            return '1 - VALUE_W'($urandom_range(0, 15));
        end
        a     = $urandom_range(0, w - 1);
        b     = (a + 1 + $urandom_range(0, w - 2)) % w;
        total = ring_val[STIM_VIEW][a] + ring_val[STIM_VIEW][b];
        if (roll < 70) return total;
        if (roll < 80) return total ^ (64'd1 << $urandom_range(0, 63));
        if (roll < 85) return ring_val[STIM_VIEW][a] << 1;
        return {$urandom, $urandom};
    endfunction

    // Queue one item and advance the stimulus view past it.
    task automatic queue_item(input logic [VALUE_W-1:0] v, input bit drain);
        t_verdict unused;
        feed_q.push_back('{value: v, drain_first: drain});
        unused = window_predict(STIM_VIEW, v);
    endtask

    // Hold until no transfer is pending and every result is back.
    task automatic wait_idle();
        while (feed_q.size() != 0 || i_in_valid || verdict_q.size() != 0)
            @(negedge i_clk);
    endtask

    // Transfer one size write; the DUT is idle whenever this runs.
    task automatic write_window(input logic [CFG_W-1:0] raw);
        @(posedge i_clk);
        i_cfg_valid   <= 1'b1;
        i_window_size <= raw;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        window_restart(DUT_VIEW, raw);
        window_restart(STIM_VIEW, raw);
        settings_run++;
    endtask

    // One random phase: write a size, fill the prelude, then checked items.
    task automatic run_phase(input logic [CFG_W-1:0] raw, input int n_checked,
                             input int hold_every, input bit steady);
        int n;
        wait_idle();
        steady_run = steady;
        write_window(raw);
        n = window_clamp(raw) + n_checked;
        for (int i = 0; i < n; i++)
            queue_item(pick_value(), hold_every != 0 && (i % hold_every) == hold_every - 1);
    endtask

    // ------------------------------------------------------------------
    // Driver: present items from feed_q; predict each one as it transfers
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_verdict due;
        t_pending nxt;
        bit       skip;
        bit       hold;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                due = window_predict(DUT_VIEW, i_value);
                verdict_q.push_back(due);
            end
            // Only a free channel takes the next item; a waiting one holds.
            if (!i_in_valid || o_in_ready) begin
                skip = !steady_run && ($urandom_range(0, 99) < 8);
                hold = feed_q.size() == 0 || skip ||
                       (feed_q[0].drain_first && verdict_q.size() != 0);
                if (hold) begin
                    i_in_valid <= 1'b0;
                end else begin
                    nxt = feed_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_value    <= nxt.value;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result transfer with the oldest expectation
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input logic want, input logic got);
        if (want !== got) begin
            $display("%0t: %s mismatch on result %0d, expected %0b, got %0b",
                     $time, name, results_seen, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %0b/%0b/%0b",
                             $time, o_checked, o_pair_found, o_first_failure);
                    error_count++;
                end else begin
                    want = verdict_q.pop_front();
                    compare_field("checked", want.checked, o_checked);
                    compare_field("pair_found", want.pair_found, o_pair_found);
                    compare_field("first_failure", want.first_failure, o_first_failure);
                    checked_seen += want.checked;
                    pairs_seen   += want.pair_found;
                    firsts_seen  += want.first_failure;
                end
                results_seen++;
            end
            // Drop ready with a chance of 8 in 100, except in the steady stretch.
            i_out_ready <= steady_run || ($urandom_range(0, 99) >= 8);
        end
    end

    // Drop the run if it hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("FAIL window_pair_sum_checker");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        logic [CFG_W-1:0] raw;
        for (int who = 0; who < 2; who++) begin
            ring_size[who]   = WINDOW_RESET;
            ring_fill[who]   = 0;
            ring_wr[who]     = 0;
            ring_failed[who] = 1'b0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening: a zero write saturates up to the minimum window.
        write_window('0);
        for (int i = 0; i < DIRECTED_N; i++) queue_item(opening_vals[i], 1'b0);

        // Sizes at and past both ends, a steady stretch, and one phase that
        // drains every result before each tenth item.
        run_phase(5'd31, 40, 0, 1'b0);
        run_phase(5'd1, 50, 0, 1'b0);
        run_phase(5'd2, 50, 0, 1'b0);
        run_phase(5'd25, 40, 0, 1'b0);
        run_phase(5'd26, 40, 0, 1'b0);
        run_phase(5'd3, 50, 0, 1'b1);
        run_phase(5'd5, 50, 10, 1'b0);
        for (int p = 0; p < 4; p++) begin
            raw = CFG_W'($urandom_range(0, 31));
            run_phase(raw, 45, 0, 1'b0);
        end

        // Drain, then give the DUT a full scan's worth of cycles to misbehave.
        wait_idle();
        repeat (MAX_WINDOW_DEF + 4) @(posedge i_clk);
        if (verdict_q.size() != 0) begin
            $display("%0t: %0d results still expected, got none", $time, verdict_q.size());
            error_count++;
        end

        $display("Ran %0d results over %0d window settings: %0d checked, %0d with a pair,",
                 results_seen, settings_run, checked_seen, pairs_seen);
        $display("%0d flagged as the first failure, %0d mismatches.",
                 firsts_seen, error_count);
        if (error_count == 0) begin
            $display("PASS window_pair_sum_checker");
        end else begin
            $display("FAIL window_pair_sum_checker");
        end
        $finish;
    end

endmodule

// ===== window_pair_sum_checker.f =====
rtl/core/wpsc_pkg.sv
rtl/core/wpsc_cell.sv
rtl/core/window_pair_sum_checker.sv
dv/tb_window_pair_sum_checker.sv
